// ===== rtl/core/pfvs_pkg.sv =====
// Shared types and constants of the page frame victim selector.
// Holds the frame entry, item and result structs and the function and policy codes.
// No dependencies.
package pfvs_pkg;

	// Default number of page frames
	localparam int FRAMES_DEF = 32;

	// Field widths
	localparam int FUNC_W  = 2;
	localparam int FRAME_W = 5;
	localparam int COIN_W  = 32;
	localparam int POL_W   = 2;

	// Packed stream widths; the tdata widths are padded to whole bytes
	localparam int IN_TDATA_W  = 40;
	localparam int IN_TUSER_W  = FUNC_W;
	localparam int OUT_TDATA_W = 8;
	localparam int OUT_TUSER_W = 1;

	// Function codes
	localparam logic [FUNC_W-1:0] FN_SELECT = 2'd0;
	localparam logic [FUNC_W-1:0] FN_REF    = 2'd1;
	localparam logic [FUNC_W-1:0] FN_PROT   = 2'd2;
	localparam logic [FUNC_W-1:0] FN_UNMAP  = 2'd3;

	// Replacement policy codes; the unused code acts as random
	localparam logic [POL_W-1:0] POL_RANDOM = 2'd0;
	localparam logic [POL_W-1:0] POL_FIFO   = 2'd1;
	localparam logic [POL_W-1:0] POL_CLOCK  = 2'd2;

	// Per-frame state bits held in the frame memory
	typedef struct packed {
		logic prot;
		logic mapped;
		logic refd;
		logic dirty;
	} pfvs_entry_t;

	// One input item
	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [FRAME_W-1:0] frame;
		logic               write_access;
		logic               protect_value;
		logic [COIN_W-1:0]  random_word;
	} pfvs_item_t;

	// One result item
	typedef struct packed {
		logic [FRAME_W-1:0] victim_frame;
		logic               evicted;
		logic               writeback;
		logic               fail;
	} pfvs_res_t;

endpackage

// ===== rtl/core/pfvs_mem.sv =====
// Frame state memory: one entry per frame, one read and one write port.
// Read data is registered; entries never written since reset read as zero.
// Depends on pfvs_pkg.
module pfvs_mem
	import pfvs_pkg::*;
#(
	parameter int DEPTH = FRAMES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output pfvs_entry_t              rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  pfvs_entry_t              wr_data
);

	pfvs_entry_t             mem [DEPTH];
	pfvs_entry_t             rdata_q;
	logic                    rvld_q;
	logic [DEPTH-1:0]        valid_q;

	// Write the array and read it through a registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Track which entries hold written data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvld_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rvld_q ? rdata_q : '0;

endmodule

// ===== rtl/core/pfvs_seq.sv =====
// Sequencer of the victim selector: frame updates, the full scan, the clock walk
// and the victim write-back, all through the frame memory's single read port.
// Depends on pfvs_pkg.
module pfvs_seq
	import pfvs_pkg::*;
#(
	parameter int FRAMES = FRAMES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [POL_W-1:0]          policy,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  pfvs_item_t                in_item,
	output logic                      res_valid,
	input  logic                      res_ready,
	output pfvs_res_t                 res,
	output logic                      rd_en,
	output logic [$clog2(FRAMES)-1:0] rd_addr,
	input  pfvs_entry_t               rd_data,
	output logic                      wr_en,
	output logic [$clog2(FRAMES)-1:0] wr_addr,
	output pfvs_entry_t               wr_data
);

	localparam int AW = $clog2(FRAMES);
	localparam logic [AW-1:0] LAST = AW'(FRAMES - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPD_RD,
		ST_UPD_WR,
		ST_SCAN,
		ST_SCAN_LAST,
		ST_DECIDE,
		ST_CLK_RD,
		ST_CLK_EV,
		ST_VIC_RD,
		ST_VIC_WR,
		ST_RESP
	} state_t;

	state_t              state_q;
	pfvs_item_t          item_q;
	pfvs_res_t           res_q;
	logic [AW-1:0]       hand_q;
	logic [AW-1:0]       scan_q;
	logic [AW-1:0]       walk_q;
	logic [AW-1:0]       vic_q;
	logic                move_hand_q;
	logic                scan_vld_s1;
	logic [AW-1:0]       idx_s1;

	// Scan results
	logic                any_q;
	logic                free_hit_q;
	logic [AW-1:0]       free_q;
	logic                coin_hit_q;
	logic [AW-1:0]       coin_q;
	logic [AW-1:0]       high_q;
	logic                low_hit_q;
	logic [AW-1:0]       low_q;
	logic                ge_hit_q;
	logic [AW-1:0]       ge_q;

	logic [6:0]          frame_ext;
	logic [AW-1:0]       frame_addr;
	logic                frame_ok;
	logic [6:0]          idx_ext;
	logic                coin;
	logic                unprot_s1;
	logic [6:0]          vic_ext;
	pfvs_entry_t         upd_entry;
	pfvs_entry_t         walk_entry;
	pfvs_entry_t         vic_entry;

	// Frame number as a memory address and range check
	assign frame_ext  = 7'(in_item.frame);
	assign frame_ok   = frame_ext < 7'(FRAMES);
	assign frame_addr = AW'(7'(item_q.frame));

	// Coin bit of the frame whose data returns this cycle; frames past the word read zero
	assign idx_ext   = 7'(idx_s1);
	assign coin      = (idx_ext < 7'(COIN_W)) && item_q.random_word[idx_ext[4:0]];
	assign unprot_s1 = !rd_data.prot;
	assign vic_ext   = 7'(vic_q);

	// Entry after a reference, protection or unmap
	always_comb begin
		upd_entry = rd_data;
		case (item_q.func)
			FN_REF: begin
				upd_entry.mapped = 1'b1;
				upd_entry.refd   = 1'b1;
				if (item_q.write_access) begin
					upd_entry.dirty = 1'b1;
				end
			end
			FN_PROT: begin
				upd_entry.prot = item_q.protect_value;
			end
			FN_UNMAP: begin
				upd_entry.mapped = 1'b0;
				upd_entry.refd   = 1'b0;
				upd_entry.dirty  = 1'b0;
			end
			default: begin
				upd_entry = rd_data;
			end
		endcase
	end

	// Clock walk clears the reference bit; the victim keeps only its protection
	always_comb begin
		walk_entry      = rd_data;
		walk_entry.refd = 1'b0;
		vic_entry       = '0;
		vic_entry.prot  = rd_data.prot;
	end

	// Memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = scan_q;
		wr_en   = 1'b0;
		wr_addr = frame_addr;
		wr_data = upd_entry;
		unique case (state_q)
			ST_UPD_RD: begin
				rd_en   = 1'b1;
				rd_addr = frame_addr;
			end
			ST_UPD_WR: begin
				wr_en   = 1'b1;
				wr_addr = frame_addr;
				wr_data = upd_entry;
			end
			ST_SCAN: begin
				rd_en   = 1'b1;
				rd_addr = scan_q;
			end
			ST_CLK_RD: begin
				rd_en   = 1'b1;
				rd_addr = walk_q;
			end
			ST_CLK_EV: begin
				wr_en   = !rd_data.prot && rd_data.refd;
				wr_addr = walk_q;
				wr_data = walk_entry;
			end
			ST_VIC_RD: begin
				rd_en   = 1'b1;
				rd_addr = vic_q;
			end
			ST_VIC_WR: begin
				wr_en   = 1'b1;
				wr_addr = vic_q;
				wr_data = vic_entry;
			end
			default: begin
				rd_en = 1'b0;
				wr_en = 1'b0;
			end
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_RESP);
	assign res       = res_q;

	// Sequence one item through the frame memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hand_q      <= '0;
			scan_vld_s1 <= 1'b0;
			move_hand_q <= 1'b0;
		end else begin
			scan_vld_s1 <= (state_q == ST_SCAN);
			idx_s1      <= scan_q;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						item_q      <= in_item;
						res_q       <= '0;
						scan_q      <= '0;
						move_hand_q <= 1'b0;
						any_q       <= 1'b0;
						free_hit_q  <= 1'b0;
						coin_hit_q  <= 1'b0;
						low_hit_q   <= 1'b0;
						ge_hit_q    <= 1'b0;
						if (in_item.func == FN_SELECT) begin
							state_q <= ST_SCAN;
						end else if (frame_ok) begin
							state_q <= ST_UPD_RD;
						end else begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_UPD_RD: begin
					state_q <= ST_UPD_WR;
				end
				ST_UPD_WR: begin
					state_q <= ST_RESP;
				end
				ST_SCAN: begin
					scan_q <= scan_q + AW'(1);
					if (scan_q == LAST) begin
						state_q <= ST_SCAN_LAST;
					end
				end
				ST_SCAN_LAST: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (!any_q) begin
						res_q.fail <= 1'b1;
						state_q    <= ST_RESP;
					end else if (free_hit_q) begin
						vic_q   <= free_q;
						state_q <= ST_VIC_RD;
					end else begin
						case (policy)
							POL_FIFO: begin
								vic_q       <= ge_hit_q ? ge_q : low_q;
								move_hand_q <= 1'b1;
								state_q     <= ST_VIC_RD;
							end
							POL_CLOCK: begin
								walk_q  <= hand_q;
								state_q <= ST_CLK_RD;
							end
							default: begin
								vic_q   <= coin_hit_q ? coin_q : high_q;
								state_q <= ST_VIC_RD;
							end
						endcase
					end
				end
				ST_CLK_RD: begin
					state_q <= ST_CLK_EV;
				end
				ST_CLK_EV: begin
					if (!rd_data.prot && !rd_data.refd) begin
						vic_q       <= walk_q;
						move_hand_q <= 1'b1;
						state_q     <= ST_VIC_RD;
					end else begin
						walk_q  <= (walk_q == LAST) ? '0 : walk_q + AW'(1);
						state_q <= ST_CLK_RD;
					end
				end
				ST_VIC_RD: begin
					state_q <= ST_VIC_WR;
				end
				ST_VIC_WR: begin
					res_q.victim_frame <= vic_ext[FRAME_W-1:0];
					res_q.evicted      <= rd_data.mapped;
					res_q.writeback    <= rd_data.mapped && rd_data.dirty;
					if (move_hand_q) begin
						hand_q <= (vic_q == LAST) ? '0 : vic_q + AW'(1);
					end
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Fold each returning entry of the scan into the candidates
			if (scan_vld_s1 && unprot_s1) begin
				any_q  <= 1'b1;
				high_q <= idx_s1;
				if (!rd_data.mapped && !free_hit_q) begin
					free_hit_q <= 1'b1;
					free_q     <= idx_s1;
				end
				if (coin && !coin_hit_q) begin
					coin_hit_q <= 1'b1;
					coin_q     <= idx_s1;
				end
				if (!low_hit_q) begin
					low_hit_q <= 1'b1;
					low_q     <= idx_s1;
				end
				if ((idx_s1 >= hand_q) && !ge_hit_q) begin
					ge_hit_q <= 1'b1;
					ge_q     <= idx_s1;
				end
			end
		end
	end

endmodule

// ===== rtl/core/page_frame_victim_selector.sv =====
// Page frame victim selector: stream ports, policy register and output register
// around the frame-memory sequencer.
// Depends on pfvs_pkg, pfvs_mem and pfvs_seq.
//
//  Channel   Direction  Handshake                      Payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tuser: func; tdata: frame..random_word
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata: victim, flags; tuser: fail
//  cfg       in         cfg_valid / cfg_ready          cfg_data: policy
//
// Reference, protect and unmap items read and write one entry.
// A victim request scans every frame through the single memory read port; a clock
// walk that follows it visits at most 2 * FRAMES frames. An item with an out-of-range
// frame does not touch the frame memory.
// Reset clears the frame bits, the hand and the policy (random); no clearing pass.
// The next item is taken while a result waits in the output register; a result
// stalls in the sequencer only while that register is still full.
module page_frame_victim_selector
	import pfvs_pkg::*;
#(
	parameter int FRAMES = FRAMES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// [4:0] frame, [5] write_access, [6] protect_value, [38:7] random_word
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// [1:0] func
	input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [4:0] victim_frame, [5] evicted, [6] writeback
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// [0] fail
	output logic [OUT_TUSER_W-1:0] m_axis_tuser,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [POL_W-1:0]       cfg_data
);

	localparam int AW = $clog2(FRAMES);

	logic [POL_W-1:0] policy_q;
	pfvs_item_t       item;
	pfvs_res_t        res;
	pfvs_res_t        out_q;
	logic             out_vld_q;
	logic             res_valid;
	logic             res_ready;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	pfvs_entry_t      rd_data;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	pfvs_entry_t      wr_data;

	// Unpack the input item
	assign item.func          = s_axis_tuser[FUNC_W-1:0];
	assign item.frame         = s_axis_tdata[4:0];
	assign item.write_access  = s_axis_tdata[5];
	assign item.protect_value = s_axis_tdata[6];
	assign item.random_word   = s_axis_tdata[38:7];

	// Hold the policy register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_RANDOM;
		end else if (cfg_valid) begin
			policy_q <= cfg_data;
		end
	end

	pfvs_mem #(
		.DEPTH(FRAMES)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	pfvs_seq #(
		.FRAMES(FRAMES)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.policy   (policy_q),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (item),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	// Output register: load when empty or being drained
	assign res_ready = !out_vld_q || m_axis_tready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	// Pack the result item
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {1'b0, out_q.writeback, out_q.evicted, out_q.victim_frame};
	assign m_axis_tuser  = out_q.fail;

endmodule
